### hw/rtl/swp_pkg.sv
// Shared types, codes and constants of the swap slot table.
package swp_pkg;

  localparam int SWAP_SLOTS  = 128;
  localparam int BLOCK_BYTES = 4;
  localparam int SLOT_IDX_W  = $clog2(SWAP_SLOTS);

  // Bits of the page word that a slot keeps
  localparam logic [31:0] WORD_MASK = (BLOCK_BYTES >= 4) ? 32'hFFFF_FFFF :
      32'((64'd1 << (8 * BLOCK_BYTES)) - 64'd1);

  typedef enum logic [1:0] {
    ACT_STORE   = 2'd0,
    ACT_FETCH   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // One slot as held in the slot memory; the used flag lives in flip-flops
  typedef struct packed {
    logic [7:0]  file;
    logic [7:0]  page;
    logic [31:0] word;
  } slot_entry_t;

  // Result of one item, handed from the controller to the output register
  typedef struct packed {
    logic        status;
    logic        hit;
    logic [31:0] data;
  } result_t;

endpackage

### hw/rtl/swp_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module swp_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/swp_ctrl.sv
// Scan sequencer: walks the slot memory, tracks matches and free slots, holds used flags.
module swp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [7:0]                    file_id,
  input  logic signed [8:0]             page_number,
  input  logic [31:0]                   page_data,
  input  logic                          out_free,
  output logic                          load,
  output swp_pkg::result_t              result,
  output logic [swp_pkg::SLOT_IDX_W-1:0] raddr,
  input  swp_pkg::slot_entry_t          rdata,
  output logic                          we,
  output logic [swp_pkg::SLOT_IDX_W-1:0] waddr,
  output swp_pkg::slot_entry_t          wdata
);
  import swp_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(SWAP_SLOTS - 1);

  state_t                state, state_next;
  logic [SLOT_IDX_W-1:0] cnt;
  logic                  rd_vld;
  logic [SLOT_IDX_W-1:0] rd_idx;
  action_t               op_q;
  logic                  neg_q;
  logic [7:0]            file_q;
  logic [7:0]            page_q;
  logic [31:0]           data_q;
  logic                  found_match;
  logic                  found_free;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic [31:0]           word_q;
  logic [SWAP_SLOTS-1:0] used;

  action_t act_in;
  logic    accept;
  logic    needs_scan;
  logic    slot_used;
  logic    file_eq;
  logic    match;

  assign act_in   = action_t'(action);
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Release scans regardless of page; store and fetch only for a non-negative page
  assign needs_scan = (act_in == ACT_RELEASE) ||
                      ((act_in == ACT_STORE || act_in == ACT_FETCH) && !page_number[8]);

  // Compare stage, in the cycle after the memory read
  assign slot_used = used[rd_idx];
  assign file_eq   = (rdata.file == file_q);
  assign match     = slot_used && file_eq && (rdata.page == page_q);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = needs_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (cnt == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Outputs
  always_comb begin
    raddr         = cnt;
    load          = 1'b0;
    we            = 1'b0;
    waddr         = free_idx;
    wdata.file    = file_q;
    wdata.page    = page_q;
    wdata.word    = data_q & WORD_MASK;
    result.status = 1'b0;
    result.hit    = 1'b0;
    result.data   = '0;
    unique case (state)
      ST_IDLE, ST_SCAN, ST_DRAIN: begin
      end
      ST_FINISH: begin
        load = out_free;
        case (op_q)
          ACT_STORE: begin
            if (!neg_q) begin
              result.hit    = found_match;
              result.status = !found_match && !found_free;
              we            = out_free && !found_match && found_free;
            end
          end
          ACT_FETCH: begin
            result.hit  = found_match;
            result.data = found_match ? word_q : '0;
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == ST_SCAN);
    end
  end

  // Capture the item on accept; the scan trackers are cleared on accept in the block below
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= act_in;
      neg_q  <= page_number[8];
      file_q <= file_id;
      page_q <= page_number[7:0];
      data_q <= page_data;
    end
  end

  // Scan address counter and read index pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt <= '0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + 1'b1;
    end
    rd_idx <= cnt;
  end

  // First match and first free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      found_match <= 1'b0;
      found_free  <= 1'b0;
    end else if (accept) begin
      found_match <= 1'b0;
      found_free  <= 1'b0;
    end else if (rd_vld) begin
      if (match && !found_match) begin
        found_match <= 1'b1;
      end
      if (!slot_used && !found_free) begin
        found_free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && match && !found_match) begin
      word_q <= rdata.word;
    end
    if (rd_vld && !slot_used && !found_free) begin
      free_idx <= rd_idx;
    end
  end

  // Used flags: set by a store, cleared by a release as the scan passes
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (rd_vld && op_q == ACT_RELEASE && slot_used && file_eq) begin
        used[rd_idx] <= 1'b0;
      end
      if (we) begin
        used[waddr] <= 1'b1;
      end
    end
  end

  a_write_free_slot: assert property (@(posedge clk) disable iff (rst)
    we |-> !used[waddr])
    else $error("store writes a slot that is in use");

  a_load_then_idle: assert property (@(posedge clk) disable iff (rst)
    load |=> state == ST_IDLE)
    else $error("result loaded without returning to idle");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("compare stage active outside a scan");

  a_full_no_hit: assert property (@(posedge clk) disable iff (rst)
    (load && result.status) |-> (!result.hit && !we))
    else $error("full status together with a hit or a write");

endmodule

### hw/rtl/swap_slot_table.sv
// Top level of the swap slot table: slot memory, scan controller and result register.
//
// Each store, fetch or release item walks every slot of the table through the single
// read port of the slot memory, one slot a cycle. Its steps are the accept, the reads of
// all SWAP_SLOTS slots, a compare of the last slot and the posting of the result. A store
// or fetch of a negative page, and the unused action code, skip the scan and go from
// accept straight to posting the result. One item is worked on at a time; in_stall is
// high from accept until the result has been moved into the output register, which then
// holds it until the receiver takes it. Used flags are cleared at reset, so the table is
// ready in the first cycle after reset.
module swap_slot_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [7:0]        file_id,
  input  logic signed [8:0] page_number,
  input  logic [31:0]       page_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              status,
  output logic              hit,
  output logic [31:0]       data_out
);
  import swp_pkg::*;

  logic                  out_free;
  logic                  load;
  result_t               result;
  logic [SLOT_IDX_W-1:0] raddr;
  slot_entry_t           rdata;
  logic                  we;
  logic [SLOT_IDX_W-1:0] waddr;
  slot_entry_t           wdata;

  assign out_free = !out_valid || !out_stall;

  swp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .file_id    (file_id),
    .page_number(page_number),
    .page_data  (page_data),
    .out_free   (out_free),
    .load       (load),
    .result     (result),
    .raddr      (raddr),
    .rdata      (rdata),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata)
  );

  swp_ram #(
    .DEPTH(SWAP_SLOTS),
    .WIDTH($bits(slot_entry_t))
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status   <= result.status;
      hit      <= result.hit;
      data_out <= result.data;
    end
  end

endmodule
